[hw/rtl/tcdr_pkg.sv]
// ----------------------------------------------------------------------------
// Text cell diff renderer package
// Shared types, sizes, codes and the cell address helper.
// ----------------------------------------------------------------------------
package tcdr_pkg;

	localparam int SCREEN_ROWS = 10;
	localparam int SCREEN_COLS = 30;
	localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
	localparam int ADDR_W      = $clog2(CELL_COUNT);
	localparam int SCAN_W      = $clog2(CELL_COUNT + 1);

	localparam int ROW_W  = 4;
	localparam int COL_W  = 5;
	localparam int CLR_W  = 4;
	localparam int CHAR_W = 8;
	localparam int TAB_W  = 5;
	localparam int ACT_W  = 3;
	localparam int KIND_W = 2;

	localparam logic [ROW_W-1:0]  ROW_MAX    = '1;
	localparam logic [COL_W-1:0]  COL_MAX    = '1;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [CLR_W-1:0]  DEF_FG     = 4'd7;
	localparam logic [CLR_W-1:0]  DEF_BG     = 4'd0;
	localparam logic [TAB_W-1:0]  TAB_RESET  = 5'd8;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUT   = 3'd0,
		ACT_POS   = 3'd1,
		ACT_COLOR = 3'd2,
		ACT_START = 3'd3,
		ACT_STEP  = 3'd4,
		ACT_CLEAR = 3'd5
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		TK_MOVE    = 2'd0,
		TK_COLOR   = 2'd1,
		TK_CHAR    = 2'd2,
		TK_NEWLINE = 2'd3
	} kind_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [CLR_W-1:0]  fg;
		logic [CLR_W-1:0]  bg;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);
	localparam cell_t BLANK_CELL = '{ch: CH_SPACE, fg: DEF_FG, bg: DEF_BG};

	typedef struct packed {
		logic             active;
		logic [CLR_W-1:0] fg;
		logic [CLR_W-1:0] bg;
	} run_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [CLR_W-1:0] fg;
		logic [CLR_W-1:0] bg;
	} track_t;

	// one slot per token kind, the mask marks the slots to send
	typedef struct packed {
		logic [3:0]        mask;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CLR_W-1:0]  fg;
		logic [CLR_W-1:0]  bg;
		logic [CHAR_W-1:0] ch;
	} tok_t;

	function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r,
		logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(r) * ADDR_W'(SCREEN_COLS) + ADDR_W'(c);
	endfunction

endpackage

[hw/rtl/text_cell_diff_renderer.sv]
// ----------------------------------------------------------------------------
// Text cell diff renderer
// Cell buffer and shadow buffer in two RAMs, with a change-only token encoder.
//
//   channel   signals                                  direction
//   in        in_valid/in_stall, action..bg            request in
//   out       out_valid/out_stall, token_kind..last    tokens out
//   cfg       cfg_we, cfg_wdata                        tab width write
//
// Put char, set position, set colors and clear are accepted directly; a tab
// holds the input for tab_q positions in S_TAB, blanking each on-screen one.
// Render step: the accept reads both RAMs, S_EVAL evaluates the cell, then
// S_EMIT sends one token per cycle unless stalled; render start sends two tokens.
// After reset and after clear, a sweep blanks all 300 cells of both RAMs
// while the input stalls; config writes are taken at any time.
// The output presents tokens from a held slot mask, so out_stall only pauses.
// ----------------------------------------------------------------------------
module text_cell_diff_renderer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tcdr_pkg::TAB_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tcdr_pkg::ACT_W-1:0]    action,
	input  logic [tcdr_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcdr_pkg::ROW_W-1:0]    row,
	input  logic [tcdr_pkg::COL_W-1:0]    col,
	input  logic [tcdr_pkg::CLR_W-1:0]    fg,
	input  logic [tcdr_pkg::CLR_W-1:0]    bg,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tcdr_pkg::KIND_W-1:0]   token_kind,
	output logic [tcdr_pkg::ROW_W-1:0]    out_row,
	output logic [tcdr_pkg::COL_W-1:0]    out_col,
	output logic [tcdr_pkg::CLR_W-1:0]    out_fg,
	output logic [tcdr_pkg::CLR_W-1:0]    out_bg,
	output logic [tcdr_pkg::CHAR_W-1:0]   out_char,
	output logic                          last
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_TAB,
		S_EVAL,
		S_EMIT
	} state_t;

	state_t                          state_q;
	logic [tcdr_pkg::TAB_W-1:0]      tab_q;
	logic [tcdr_pkg::TAB_W-1:0]      tab_cnt_q;
	logic [tcdr_pkg::ADDR_W-1:0]     clr_q;
	logic [tcdr_pkg::ROW_W-1:0]      wr_row_q;
	logic [tcdr_pkg::COL_W-1:0]      wr_col_q;
	logic [tcdr_pkg::CLR_W-1:0]      pen_fg_q;
	logic [tcdr_pkg::CLR_W-1:0]      pen_bg_q;
	logic [tcdr_pkg::SCAN_W-1:0]     scan_q;
	logic [tcdr_pkg::ROW_W-1:0]      scan_row_q;
	logic [tcdr_pkg::COL_W-1:0]      scan_col_q;
	tcdr_pkg::run_t                  run_q;
	tcdr_pkg::track_t                track_q;
	tcdr_pkg::tok_t                  tok_q;

	logic                            in_accept, out_accept;
	logic                            scan_live, on_screen, is_step_read;
	logic                            frm_we, shd_we;
	logic [tcdr_pkg::ADDR_W-1:0]     frm_waddr, shd_waddr, rd_addr;
	tcdr_pkg::cell_t                 frm_wdata, shd_wdata, frm_rdata, shd_rdata;
	tcdr_pkg::run_t                  run_nx;
	tcdr_pkg::track_t                track_nx;
	tcdr_pkg::tok_t                  tok_nx;
	logic                            enc_shadow_we;
	logic [tcdr_pkg::KIND_W-1:0]     slot;
	logic [3:0]                      mask_left;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = (state_q == S_EMIT);
	assign out_accept = out_valid && !out_stall;

	assign scan_live = (scan_q < tcdr_pkg::SCAN_W'(tcdr_pkg::CELL_COUNT));
	assign on_screen = (wr_row_q < tcdr_pkg::ROW_W'(tcdr_pkg::SCREEN_ROWS))
		&& (wr_col_q < tcdr_pkg::COL_W'(tcdr_pkg::SCREEN_COLS));
	assign is_step_read = in_accept && (action == tcdr_pkg::ACT_STEP) && scan_live;
	assign rd_addr = scan_q[tcdr_pkg::ADDR_W-1:0];

	// frame write port: sweep, tab fill or single put
	always_comb begin
		frm_we    = 1'b0;
		frm_waddr = tcdr_pkg::cell_addr(wr_row_q, wr_col_q);
		frm_wdata = tcdr_pkg::BLANK_CELL;
		case (state_q)
			S_CLEAR: begin
				frm_we    = 1'b1;
				frm_waddr = clr_q;
			end
			S_TAB: begin
				frm_we = on_screen;
				frm_wdata = '{ch: tcdr_pkg::CH_SPACE, fg: pen_fg_q, bg: pen_bg_q};
			end
			S_IDLE: begin
				frm_we = in_accept && (action == tcdr_pkg::ACT_PUT) && on_screen
					&& (char_code != tcdr_pkg::CH_NEWLINE)
					&& (char_code != tcdr_pkg::CH_TAB);
				frm_wdata = '{ch: char_code, fg: pen_fg_q, bg: pen_bg_q};
			end
			default: begin
				frm_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		shd_we    = 1'b0;
		shd_waddr = clr_q;
		shd_wdata = tcdr_pkg::BLANK_CELL;
		if (state_q == S_CLEAR) begin
			shd_we = 1'b1;
		end else if (state_q == S_EVAL) begin
			shd_we    = enc_shadow_we;
			shd_waddr = rd_addr;
			shd_wdata = frm_rdata;
		end
	end

	tcdr_ram #(.WIDTH(tcdr_pkg::CELL_W), .DEPTH(tcdr_pkg::CELL_COUNT)) u_frame (
		.clk   (clk),
		.we    (frm_we),
		.waddr (frm_waddr),
		.wdata (frm_wdata),
		.re    (is_step_read),
		.raddr (rd_addr),
		.rdata (frm_rdata)
	);

	tcdr_ram #(.WIDTH(tcdr_pkg::CELL_W), .DEPTH(tcdr_pkg::CELL_COUNT)) u_shadow (
		.clk   (clk),
		.we    (shd_we),
		.waddr (shd_waddr),
		.wdata (shd_wdata),
		.re    (is_step_read),
		.raddr (rd_addr),
		.rdata (shd_rdata)
	);

	tcdr_encoder u_encoder (
		.frame_cell (frm_rdata),
		.shadow     (shd_rdata),
		.run        (run_q),
		.track      (track_q),
		.scan_row   (scan_row_q),
		.scan_col   (scan_col_q),
		.run_nx     (run_nx),
		.track_nx   (track_nx),
		.tok        (tok_nx),
		.shadow_we  (enc_shadow_we)
	);

	// lowest pending slot goes out first
	always_comb begin
		if (tok_q.mask[tcdr_pkg::TK_MOVE]) begin
			slot = tcdr_pkg::TK_MOVE;
		end else if (tok_q.mask[tcdr_pkg::TK_COLOR]) begin
			slot = tcdr_pkg::TK_COLOR;
		end else if (tok_q.mask[tcdr_pkg::TK_CHAR]) begin
			slot = tcdr_pkg::TK_CHAR;
		end else begin
			slot = tcdr_pkg::TK_NEWLINE;
		end
		mask_left       = tok_q.mask;
		mask_left[slot] = 1'b0;
	end

	assign token_kind = slot;
	assign out_row  = (slot == tcdr_pkg::TK_MOVE)  ? tok_q.row : '0;
	assign out_col  = (slot == tcdr_pkg::TK_MOVE)  ? tok_q.col : '0;
	assign out_fg   = (slot == tcdr_pkg::TK_COLOR) ? tok_q.fg  : '0;
	assign out_bg   = (slot == tcdr_pkg::TK_COLOR) ? tok_q.bg  : '0;
	assign out_char = (slot == tcdr_pkg::TK_CHAR)  ? tok_q.ch  : '0;
	assign last     = (mask_left == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			tab_q      <= tcdr_pkg::TAB_RESET;
			tab_cnt_q  <= '0;
			clr_q      <= '0;
			wr_row_q   <= '0;
			wr_col_q   <= '0;
			pen_fg_q   <= tcdr_pkg::DEF_FG;
			pen_bg_q   <= tcdr_pkg::DEF_BG;
			scan_q     <= '0;
			scan_row_q <= '0;
			scan_col_q <= '0;
			run_q      <= '{active: 1'b0, fg: tcdr_pkg::DEF_FG, bg: tcdr_pkg::DEF_BG};
			track_q    <= '{row: '0, col: '0, fg: tcdr_pkg::DEF_FG, bg: tcdr_pkg::DEF_BG};
			tok_q      <= '0;
		end else begin
			if (cfg_we) begin
				tab_q <= cfg_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == tcdr_pkg::ADDR_W'(tcdr_pkg::CELL_COUNT - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_TAB: begin
					if (wr_col_q != tcdr_pkg::COL_MAX) begin
						wr_col_q <= wr_col_q + 1'b1;
					end
					tab_cnt_q <= tab_cnt_q - 1'b1;
					if (tab_cnt_q == tcdr_pkg::TAB_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_EVAL: begin
					run_q   <= run_nx;
					track_q <= track_nx;
					tok_q   <= tok_nx;
					scan_q  <= scan_q + 1'b1;
					if (scan_col_q == tcdr_pkg::COL_W'(tcdr_pkg::SCREEN_COLS - 1)) begin
						scan_col_q <= '0;
						scan_row_q <= scan_row_q + 1'b1;
					end else begin
						scan_col_q <= scan_col_q + 1'b1;
					end
					state_q <= (tok_nx.mask != 4'd0) ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (out_accept) begin
						tok_q.mask <= mask_left;
						if (mask_left == 4'd0) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						case (action)
							tcdr_pkg::ACT_PUT: begin
								if (char_code == tcdr_pkg::CH_NEWLINE) begin
									if (wr_row_q != tcdr_pkg::ROW_MAX) begin
										wr_row_q <= wr_row_q + 1'b1;
									end
									wr_col_q <= '0;
								end else if (char_code == tcdr_pkg::CH_TAB) begin
									tab_cnt_q <= tab_q;
									if (tab_q != '0) begin
										state_q <= S_TAB;
									end
								end else if (wr_col_q != tcdr_pkg::COL_MAX) begin
									wr_col_q <= wr_col_q + 1'b1;
								end
							end
							tcdr_pkg::ACT_POS: begin
								wr_row_q <= row;
								wr_col_q <= col;
							end
							tcdr_pkg::ACT_COLOR: begin
								pen_fg_q <= fg;
								pen_bg_q <= bg;
							end
							tcdr_pkg::ACT_START: begin
								track_q <= '{row: '0, col: '0,
									fg: tcdr_pkg::DEF_FG, bg: tcdr_pkg::DEF_BG};
								scan_q       <= '0;
								scan_row_q   <= '0;
								scan_col_q   <= '0;
								run_q.active <= 1'b0;
								tok_q <= '{mask: 4'b0011, row: '0, col: '0,
									fg: tcdr_pkg::DEF_FG, bg: tcdr_pkg::DEF_BG, ch: '0};
								state_q <= S_EMIT;
							end
							tcdr_pkg::ACT_STEP: begin
								if (scan_live) begin
									state_q <= S_EVAL;
								end else begin
									run_q.active <= 1'b0;
								end
							end
							tcdr_pkg::ACT_CLEAR: begin
								wr_row_q <= '0;
								wr_col_q <= '0;
								clr_q    <= '0;
								state_q  <= S_CLEAR;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_step_reads: assert property (@(posedge clk) disable iff (!arst_n)
		is_step_read |=> state_q == S_EVAL)
		else $error("render step read not followed by evaluation");

	a_shadow_owner: assert property (@(posedge clk) disable iff (!arst_n)
		shd_we |-> (state_q == S_EVAL || state_q == S_CLEAR))
		else $error("shadow written outside evaluation or sweep");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frm_we |-> frm_waddr < tcdr_pkg::ADDR_W'(tcdr_pkg::CELL_COUNT))
		else $error("frame write beyond the screen");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && last) |=> !out_valid)
		else $error("token sent after the final token of a request");

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tok_q.mask != 4'd0)
		else $error("token presented with no slot pending");

endmodule

[hw/rtl/tcdr_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcdr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 300
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/tcdr_encoder.sv]
// ----------------------------------------------------------------------------
// Text cell diff renderer encoder
// Compares one scanned cell with its shadow, updates the run and the tracked
// output state, and lays out the tokens for that cell.
// ----------------------------------------------------------------------------
module tcdr_encoder (
	input  tcdr_pkg::cell_t                frame_cell,
	input  tcdr_pkg::cell_t                shadow,
	input  tcdr_pkg::run_t                 run,
	input  tcdr_pkg::track_t               track,
	input  logic [tcdr_pkg::ROW_W-1:0]     scan_row,
	input  logic [tcdr_pkg::COL_W-1:0]     scan_col,
	output tcdr_pkg::run_t                 run_nx,
	output tcdr_pkg::track_t               track_nx,
	output tcdr_pkg::tok_t                 tok,
	output logic                           shadow_we
);

	logic cell_blank, shd_blank, differ, similar, keep, open, act;
	logic row_end;

	always_comb begin
		cell_blank = (frame_cell.ch == tcdr_pkg::CH_SPACE) || (frame_cell.fg == frame_cell.bg);
		shd_blank  = (shadow.ch == tcdr_pkg::CH_SPACE) || (shadow.fg == shadow.bg);
		if (cell_blank && shd_blank) begin
			differ = (frame_cell.bg != shadow.bg);
		end else begin
			differ = (frame_cell != shadow);
		end
		if ((run.fg == run.bg) || cell_blank) begin
			similar = (run.bg == frame_cell.bg);
		end else begin
			similar = (run.fg == frame_cell.fg) && (run.bg == frame_cell.bg);
		end
		keep    = run.active && similar;
		open    = !keep && differ;
		act     = keep || open;
		row_end = (scan_col == tcdr_pkg::COL_W'(tcdr_pkg::SCREEN_COLS - 1));

		run_nx.active = act;
		run_nx.fg     = open ? frame_cell.fg : run.fg;
		run_nx.bg     = open ? frame_cell.bg : run.bg;

		tok      = '0;
		track_nx = track;
		if (open) begin
			tok.mask[tcdr_pkg::TK_MOVE]  = (track.row != scan_row)
				|| (track.col != scan_col);
			tok.mask[tcdr_pkg::TK_COLOR] = (track.fg != frame_cell.fg)
				|| (track.bg != frame_cell.bg);
			tok.row  = scan_row;
			tok.col  = scan_col;
			tok.fg   = frame_cell.fg;
			tok.bg   = frame_cell.bg;
			track_nx = '{row: scan_row, col: scan_col, fg: frame_cell.fg, bg: frame_cell.bg};
		end
		if (act) begin
			tok.mask[tcdr_pkg::TK_CHAR] = 1'b1;
			tok.ch = (frame_cell.fg == frame_cell.bg) ? tcdr_pkg::CH_SPACE : frame_cell.ch;
			if (row_end) begin
				tok.mask[tcdr_pkg::TK_NEWLINE] = 1'b1;
				if (track_nx.row != tcdr_pkg::ROW_MAX) begin
					track_nx.row = track_nx.row + 1'b1;
				end
				track_nx.col = '0;
			end else if (track_nx.col != tcdr_pkg::COL_MAX) begin
				track_nx.col = track_nx.col + 1'b1;
			end
		end
		shadow_we = act;
	end

endmodule
